// ----- sv/gtaca_pkg.sv -----
// Shared types, constants and tables of the grayscale to ASCII cell averager.
// Imported by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package gtaca_pkg;

  // Default sizing of the top level parameters.
  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_DIM_DEF  = 4096;

  // Field widths.
  localparam int PIX_W   = 8;
  localparam int CHAR_W  = 7;
  localparam int LVL_W   = 4;
  localparam int OCOL_W  = 8;
  localparam int OROW_W  = 12;
  localparam int TDATA_W = 32;

  // Accumulator and divider widths.
  localparam int SUM_W  = 32;
  localparam int CNT_W  = 25;
  localparam int AVG_W  = 8;
  localparam int DVS_W  = CNT_W + AVG_W - 1;
  localparam int STEP_W = $clog2(AVG_W);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int DIM_REG_W  = 13;
  localparam int COLS_REG_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_CHAR_COLS    = 3'd2,
    CFG_CHAR_ROWS    = 3'd3
  } cfg_index_e;

  localparam logic [DIM_REG_W-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [DIM_REG_W-1:0]  HEIGHT_RST = 13'd480;
  localparam logic [COLS_REG_W-1:0] COLS_RST   = 9'd150;
  localparam logic [DIM_REG_W-1:0]  ROWS_RST   = 13'd51;

  // Brightness ramp. A level k is reached once avg * 9 >= 255 * k, so each
  // threshold is the ceiling of 255 * k / 9.
  localparam int NUM_LEVELS = 10;

  localparam logic [AVG_W-1:0] LEVEL_THR [NUM_LEVELS-1] = '{
    8'd29, 8'd57, 8'd85, 8'd114, 8'd142, 8'd170, 8'd199, 8'd227, 8'd255
  };

  // ASCII codes of " .:-=+*#%@".
  localparam logic [CHAR_W-1:0] RAMP_CHARS [NUM_LEVELS] = '{
    7'd32, 7'd46, 7'd58, 7'd45, 7'd61, 7'd43, 7'd42, 7'd35, 7'd37, 7'd64
  };

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic accumulate;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;
    logic div_last;
  } dp_status_t;

  // Quantizes an average brightness by parallel threshold compares.
  function automatic logic [LVL_W-1:0] level_of(input logic [AVG_W-1:0] avg);
    logic [LVL_W-1:0] lvl;
    lvl = '0;
    for (int k = 0; k < NUM_LEVELS - 1; k++) begin
      if (avg >= LEVEL_THR[k]) begin
        lvl = lvl + LVL_W'(1);
      end
    end
    return lvl;
  endfunction

endpackage

// ----- sv/gtaca_ctrl.sv -----
// Controller state machine of the cell averager: sequences accept, accumulate,
// divide and output load. Depends on gtaca_pkg.
`timescale 1ns / 1ps

module gtaca_ctrl import gtaca_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = status_i.emit ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    cmd_o.accept      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.accumulate  = (state_q == ST_ACC);
    cmd_o.div_step    = (state_q == ST_DIV);
    cmd_o.out_load    = (state_q == ST_OUT) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/gtaca_dp.sv -----
// Datapath of the cell averager: raster position and cell tracking, column
// accumulator memory, restoring divider and ramp lookup. Depends on gtaca_pkg.
`timescale 1ns / 1ps

module gtaca_dp import gtaca_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_DIM  = MAX_DIM_DEF,
  localparam int DW = $clog2(MAX_DIM + 1),
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              restart_i,
  input  logic [DW-1:0]     eff_w_i,
  input  logic [DW-1:0]     eff_h_i,
  input  logic [DW-1:0]     eff_c_i,
  input  logic [DW-1:0]     eff_r_i,
  input  logic [PIX_W-1:0]  pixel_i,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  output logic [CHAR_W-1:0] char_code_o,
  output logic [LVL_W-1:0]  level_o,
  output logic [OCOL_W-1:0] cell_col_o,
  output logic [OROW_W-1:0] cell_row_o,
  output logic              row_end_o,
  output logic              frame_end_o
);

  localparam int ACC_W = SUM_W + CNT_W;

  // Position of the next pixel, with the remainders of x*C/W and y*R/H.
  logic [DW-1:0] x_q, xrem_q, y_q, yrem_q, row_q;
  logic [CW-1:0] col_q;
  logic          firstx_q, firsty_q;

  logic [DW:0] x1, xr_sum, y1, yr_sum;
  logic        last_xe, xcross, last_x, last_ye, ycross, last_y, fresh;

  // Column accumulators for the current band of cell rows.
  logic [ACC_W-1:0] mem [MAX_COLS];
  logic [ACC_W-1:0] rd_q;
  logic [PIX_W-1:0] pix_q;
  logic [SUM_W-1:0] new_sum;
  logic [CNT_W-1:0] new_cnt;

  // Cell that the current division belongs to.
  logic [CW-1:0] res_col_q;
  logic [DW-1:0] res_row_q;
  logic          res_row_end_q, res_frame_end_q;

  // Restoring divider, one quotient bit a step.
  logic [SUM_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [AVG_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;
  logic              ge;

  // Output register.
  logic [CHAR_W-1:0] char_q;
  logic [LVL_W-1:0]  lvl_q;
  logic [OCOL_W-1:0] ocol_q;
  logic [OROW_W-1:0] orow_q;
  logic              orow_end_q, oframe_end_q;
  logic [LVL_W-1:0]  lvl_new;
  logic [31:0]       col_ext, row_ext;

  // The column index steps up exactly when the remainder passes the width,
  // since C never exceeds W; the same holds for rows.
  always_comb begin
    x1      = {1'b0, x_q} + (DW+1)'(1);
    xr_sum  = {1'b0, xrem_q} + {1'b0, eff_c_i};
    last_xe = (x1 == {1'b0, eff_w_i});
    xcross  = (xr_sum >= {1'b0, eff_w_i});
    last_x  = last_xe || xcross;
    y1      = {1'b0, y_q} + (DW+1)'(1);
    yr_sum  = {1'b0, yrem_q} + {1'b0, eff_r_i};
    last_ye = (y1 == {1'b0, eff_h_i});
    ycross  = (yr_sum >= {1'b0, eff_h_i});
    last_y  = last_ye || ycross;
    // The first pixel of a cell starts its sum afresh, so the memory never
    // needs clearing.
    fresh   = firstx_q && firsty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      xrem_q   <= '0;
      col_q    <= '0;
      firstx_q <= 1'b1;
      y_q      <= '0;
      yrem_q   <= '0;
      row_q    <= '0;
      firsty_q <= 1'b1;
    end else if (restart_i) begin
      x_q      <= '0;
      xrem_q   <= '0;
      col_q    <= '0;
      firstx_q <= 1'b1;
      y_q      <= '0;
      yrem_q   <= '0;
      row_q    <= '0;
      firsty_q <= 1'b1;
    end else if (cmd_i.accumulate) begin
      if (last_xe) begin
        x_q      <= '0;
        xrem_q   <= '0;
        col_q    <= '0;
        firstx_q <= 1'b1;
        if (last_ye) begin
          y_q      <= '0;
          yrem_q   <= '0;
          row_q    <= '0;
          firsty_q <= 1'b1;
        end else begin
          y_q      <= y1[DW-1:0];
          yrem_q   <= ycross ? DW'(yr_sum - {1'b0, eff_h_i}) : yr_sum[DW-1:0];
          row_q    <= ycross ? row_q + DW'(1) : row_q;
          firsty_q <= last_y;
        end
      end else begin
        x_q      <= x1[DW-1:0];
        xrem_q   <= xcross ? DW'(xr_sum - {1'b0, eff_w_i}) : xr_sum[DW-1:0];
        col_q    <= xcross ? col_q + CW'(1) : col_q;
        firstx_q <= xcross;
      end
    end
  end

  always_comb begin
    new_sum = (fresh ? '0 : rd_q[ACC_W-1:CNT_W]) + SUM_W'(pix_q);
    new_cnt = (fresh ? '0 : rd_q[CNT_W-1:0]) + CNT_W'(1);
  end

  // The read issued with the accept is back in time for the accumulate step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q  <= mem[col_q];
      pix_q <= pixel_i;
    end
    if (cmd_i.accumulate) begin
      mem[col_q] <= {new_sum, new_cnt};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accumulate) begin
      res_col_q       <= col_q;
      res_row_q       <= row_q;
      res_row_end_q   <= (32'(col_q) + 32'd1) == 32'(eff_c_i);
      res_frame_end_q <= last_xe && last_ye;
    end
  end

  // The average never exceeds 255, so eight quotient bits suffice.
  assign ge = (dvs_q != '0) && (rem_q >= SUM_W'(dvs_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accumulate) begin
      rem_q <= new_sum;
      dvs_q <= {new_cnt, {(AVG_W-1){1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_q - SUM_W'(dvs_q);
      end
      dvs_q <= dvs_q >> 1;
      quo_q <= {quo_q[AVG_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.accumulate) begin
      step_q <= STEP_W'(AVG_W - 1);
    end else if (cmd_i.div_step) begin
      step_q <= step_q - STEP_W'(1);
    end
  end

  always_comb begin
    lvl_new = level_of(quo_q);
    col_ext = 32'(res_col_q);
    row_ext = 32'(res_row_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      char_q       <= RAMP_CHARS[lvl_new];
      lvl_q        <= lvl_new;
      ocol_q       <= col_ext[OCOL_W-1:0];
      orow_q       <= row_ext[OROW_W-1:0];
      orow_end_q   <= res_row_end_q;
      oframe_end_q <= res_frame_end_q;
    end
  end

  assign status_o.emit     = last_x && last_y;
  assign status_o.div_last = (step_q == '0);

  assign char_code_o = char_q;
  assign level_o     = lvl_q;
  assign cell_col_o  = ocol_q;
  assign cell_row_o  = orow_q;
  assign row_end_o   = orow_end_q;
  assign frame_end_o = oframe_end_q;

endmodule

// ----- sv/gray_to_ascii_cell_averager.sv -----
// Grayscale to ASCII-art cell averager: top level with configuration registers.
// Depends on gtaca_pkg, gtaca_ctrl and gtaca_dp.
// A pixel that closes no cell passes through accept and accumulate; one that
// closes a cell passes through accept, accumulate, 8 divider steps and load,
// and the load waits while a held result is not yet taken. A new pixel is
// taken only once the last is through. Reset: asynchronous, active low;
// registers return to 640x480 and 150x51 cells.
`timescale 1ns / 1ps

module gray_to_ascii_cell_averager import gtaca_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_DIM  = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write request.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Pixel stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel
  // Cell stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [6:0] char_code, [10:7] level, [18:11] cell_col, [30:19] cell_row, [31] zero
  output logic [TDATA_W-1:0]    m_axis_tdata,
  output logic                  m_axis_tuser,   // [0] row_end
  output logic                  m_axis_tlast    // frame_end
);

  localparam int DW = $clog2(MAX_DIM + 1);

  // The sequencing is plain: the controller accepts a pixel only when it is
  // idle, the datapath reads the column accumulator in that same cycle and
  // writes it back in the next. When the pixel closes a cell, the datapath
  // divides the cell sum by its count one bit per cycle, and the ramp lookup
  // is folded into the load of the output register. The output register lets
  // the next pixel in while a finished cell still waits downstream.

  logic [DIM_REG_W-1:0]  cfg_width_q, cfg_height_q, cfg_rows_q;
  logic [COLS_REG_W-1:0] cfg_cols_q;
  logic                  cfg_we, cfg_known, restart;

  // Configuration writes are always taken. A write to a known register also
  // restarts the frame; any other index is dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    case (cfg_index_i)
      CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_CHAR_COLS, CFG_CHAR_ROWS: begin
        cfg_known = 1'b1;
      end
      default: begin
        cfg_known = 1'b0;
      end
    endcase
  end

  assign restart = cfg_we && cfg_known;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RST;
      cfg_height_q <= HEIGHT_RST;
      cfg_cols_q   <= COLS_RST;
      cfg_rows_q   <= ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH: begin
          cfg_width_q <= cfg_data_i[DIM_REG_W-1:0];
        end
        CFG_IMAGE_HEIGHT: begin
          cfg_height_q <= cfg_data_i[DIM_REG_W-1:0];
        end
        CFG_CHAR_COLS: begin
          cfg_cols_q <= cfg_data_i[COLS_REG_W-1:0];
        end
        CFG_CHAR_ROWS: begin
          cfg_rows_q <= cfg_data_i[DIM_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Effective sizes. The image is clamped to the supported dimension, and the
  // cell grid to the image, so that every cell receives at least one pixel.
  logic [31:0]   w32, h32, cmax32, c32, r32;
  logic [DW-1:0] eff_w, eff_h, eff_c, eff_r;

  always_comb begin
    w32 = 32'(cfg_width_q);
    if (w32 == 32'd0) begin
      w32 = 32'd1;
    end else if (w32 > 32'(MAX_DIM)) begin
      w32 = 32'(MAX_DIM);
    end
    h32 = 32'(cfg_height_q);
    if (h32 == 32'd0) begin
      h32 = 32'd1;
    end else if (h32 > 32'(MAX_DIM)) begin
      h32 = 32'(MAX_DIM);
    end
    cmax32 = (32'(MAX_COLS) < w32) ? 32'(MAX_COLS) : w32;
    c32 = 32'(cfg_cols_q);
    if (c32 == 32'd0) begin
      c32 = 32'd1;
    end else if (c32 > cmax32) begin
      c32 = cmax32;
    end
    r32 = 32'(cfg_rows_q);
    if (r32 == 32'd0) begin
      r32 = 32'd1;
    end else if (r32 > h32) begin
      r32 = h32;
    end
    eff_w = w32[DW-1:0];
    eff_h = h32[DW-1:0];
    eff_c = c32[DW-1:0];
    eff_r = r32[DW-1:0];
  end

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [CHAR_W-1:0] char_code;
  logic [LVL_W-1:0]  level;
  logic [OCOL_W-1:0] cell_col;
  logic [OROW_W-1:0] cell_row;
  logic              row_end, frame_end;

  gtaca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gtaca_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_DIM  (MAX_DIM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .eff_w_i     (eff_w),
    .eff_h_i     (eff_h),
    .eff_c_i     (eff_c),
    .eff_r_i     (eff_r),
    .pixel_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .char_code_o (char_code),
    .level_o     (level),
    .cell_col_o  (cell_col),
    .cell_row_o  (cell_row),
    .row_end_o   (row_end),
    .frame_end_o (frame_end)
  );

  // Fields are packed from the lowest bit up, with a zero pad to 32 bits.
  assign m_axis_tdata = {1'b0, cell_row, cell_col, level, char_code};
  assign m_axis_tuser = row_end;
  assign m_axis_tlast = frame_end;

endmodule
